// ===== hw/rtl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 16;
    localparam logic [31:0] TICKS_PER_S_RESET = 32'd1000000;
    localparam int unsigned MS_PER_S = 1000;

    // command codes on the input port
    localparam logic [2:0] CMD_ENQUEUE  = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_SET_PRIO = 3'd2;
    localparam logic [2:0] CMD_SLEEP    = 3'd3;
    localparam logic [2:0] CMD_WAKE     = 3'd4;
    localparam logic [2:0] CMD_SCHEDULE = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_PRESENT = 2'd2;
    localparam logic [1:0] STAT_NO_CUR  = 2'd3;

    typedef enum logic [2:0] {
        OP_ENQUEUE,
        OP_REMOVE,
        OP_SET_PRIO,
        OP_SLEEP,
        OP_WAKE,
        OP_SCHEDULE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        TS_READY,
        TS_RUNNING,
        TS_SLEEPING
    } tstate_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EXEC,
        B_MUL,
        B_DIV_GO,
        B_DIV,
        B_SLEEP_WR,
        B_SCAN,
        B_COMMIT_OLD,
        B_COMMIT_NEW
    } bstate_t;

    typedef struct packed {
        op_t         op;
        logic        slot_ok;
        logic [3:0]  slot;
        logic [7:0]  prio;
        logic [31:0] sleep_ms;
        logic [63:0] now;
    } item_t;

    typedef struct packed {
        logic        present;
        tstate_t     ts;
        logic [7:0]  prio;
        logic [63:0] wake;
        logic [31:0] stamp;
    } entry_t;

endpackage

// ===== hw/rtl/priority_thread_scheduler_unit.sv =====
`timescale 1ns / 1ps
// strict priority thread scheduler with timed wake
// command channel: a transaction is taken on a rising edge with start high and
// busy low; command, slot, priority_req, sleep_ms and now_ticks travel with it.
// a two-entry command queue sits between the intake and the execution engine,
// so busy rises only when the queue is full.
// results: one per command, shown for a single cycle with done high; status,
// chosen_slot, switched and running_slot are valid only then. the receiver
// cannot stall, so each result is taken as it appears.
// path from a start to its done cycle: enqueue, remove, set priority, wake,
// unknown commands and sleep with idle running go through the queue, dispatch
// and an execute step on the single read-modify-write table port; schedule
// reads the table one slot per cycle from slot 1 up, then commits the old
// running thread and, when it changes, the new one; sleep adds the tick
// multiply and a divide by 1000 in four 16-bit digit steps before its write.
// with the queue full the next command starts in its predecessor's done cycle.
// configuration: cfg_data is written into the ticks-per-second register on any
// cycle with cfg_valid high; cfg_ready is always high.
// reset clears the slot table, the enqueue counter and the queue at once, and
// sets the running slot to idle; commands are taken once reset is released.
module priority_thread_scheduler_unit import pts_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [3:0]  slot,
    input  logic [7:0]  priority_req,
    input  logic [31:0] sleep_ms,
    input  logic [63:0] now_ticks,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  chosen_slot,
    output logic        switched,
    output logic [3:0]  running_slot
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    pts_front #(.NUM_SLOTS(NUM_SLOTS)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .slot         (slot),
        .priority_req (priority_req),
        .sleep_ms     (sleep_ms),
        .now_ticks    (now_ticks),
        .busy         (busy),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    pts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .chosen_slot  (chosen_slot),
        .switched     (switched),
        .running_slot (running_slot)
    );

endmodule

// ===== hw/rtl/pts_front.sv =====
`timescale 1ns / 1ps

module pts_front import pts_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  command,
    input  logic [3:0]  slot,
    input  logic [7:0]  priority_req,
    input  logic [31:0] sleep_ms,
    input  logic [63:0] now_ticks,
    output logic        busy,
    output item_t       q_item,
    output logic        q_valid,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    item_t      in_item;

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    // classify the command and check the slot range up front
    always_comb
    begin
        in_item.slot     = slot;
        in_item.prio     = priority_req;
        in_item.sleep_ms = sleep_ms;
        in_item.now      = now_ticks;
        in_item.slot_ok  = (slot != 4'd0) && (32'(slot) < NUM_SLOTS);
        case (command)
            CMD_ENQUEUE:  in_item.op = OP_ENQUEUE;
            CMD_REMOVE:   in_item.op = OP_REMOVE;
            CMD_SET_PRIO: in_item.op = OP_SET_PRIO;
            CMD_SLEEP:    in_item.op = OP_SLEEP;
            CMD_WAKE:     in_item.op = OP_WAKE;
            CMD_SCHEDULE: in_item.op = OP_SCHEDULE;
            default:      in_item.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/pts_div.sv =====
`timescale 1ns / 1ps

module pts_div import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient
);

    localparam logic [9:0]  DIVISOR     = 10'(MS_PER_S);
    // ceil(2^36 / 1000), exact for every partial dividend below 1000 * 2^16
    localparam logic [26:0] RECIP       = 27'd68719477;
    localparam int unsigned RECIP_SHIFT = 36;

    logic [9:0]  rem_reg;
    logic [9:0]  rem_next;
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [15:0] qd_reg;
    logic [15:0] qd_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        phase_reg;
    logic        phase_next;
    logic        run_reg;
    logic        run_next;
    logic        done_reg;
    logic        done_next;
    logic [25:0] part;
    logic [52:0] recip_prod;
    logic [25:0] qd_times;

    assign part       = {rem_reg, quo_reg[63:48]};
    assign recip_prod = 53'(part) * 53'(RECIP);
    assign qd_times   = 26'(qd_reg) * 26'(DIVISOR);
    assign done       = done_reg;
    assign quotient   = quo_reg;

    // long division by 1000 in 16-bit digits, each digit a
    // reciprocal multiply for the quotient digit, then the remainder
    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        qd_next    = qd_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (go)
        begin
            rem_next   = 10'd0;
            quo_next   = dividend;
            cnt_next   = 2'd0;
            phase_next = 1'b0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            if (!phase_reg)
            begin
                qd_next    = recip_prod[RECIP_SHIFT +: 16];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = 10'(part - qd_times);
                quo_next   = {quo_reg[47:0], qd_reg};
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        qd_reg  <= qd_next;
    end

endmodule

// ===== hw/rtl/pts_back.sv =====
`timescale 1ns / 1ps

module pts_back import pts_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       q_item,
    input  logic        q_valid,
    output logic        q_pop,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  chosen_slot,
    output logic        switched,
    output logic [3:0]  running_slot
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W:0] SCAN_LAST = (IDX_W + 1)'(NUM_SLOTS - 1);

    entry_t      tab_reg [NUM_SLOTS];
    bstate_t     st_reg;
    bstate_t     st_next;
    item_t       cur_reg;
    item_t       cur_next;
    logic [31:0] tps_reg;
    logic [31:0] counter_reg;
    logic [31:0] counter_next;
    logic [3:0]  running_reg;
    logic [3:0]  running_next;
    logic [IDX_W:0] scan_reg;
    logic [IDX_W:0] scan_next;
    logic        found_reg;
    logic        found_next;
    logic [3:0]  best_reg;
    logic [3:0]  best_next;
    logic [7:0]  best_prio_reg;
    logic [7:0]  best_prio_next;
    logic [31:0] best_stamp_reg;
    logic [31:0] best_stamp_next;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic        done_reg;
    logic        done_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [3:0]  chosen_reg;
    logic [3:0]  chosen_next;
    logic        switched_reg;
    logic        switched_next;

    logic [IDX_W-1:0] rd_idx;
    entry_t      rd_e;
    entry_t      wr_e;
    logic        tab_we;
    logic [31:0] slot_w;
    logic [31:0] run_w;
    logic [31:0] best_w;
    logic [31:0] scan_w;
    logic [3:0]  scan_slot;
    logic [3:0]  pick;
    logic        in_use;
    logic        div_go;
    logic        div_done;
    logic [63:0] div_q;
    logic [64:0] wake_sum;
    tstate_t     scan_ts;
    logic        scan_due;

    assign slot_w    = 32'(cur_reg.slot);
    assign run_w     = 32'(running_reg);
    assign best_w    = 32'(best_reg);
    assign scan_w    = 32'(scan_reg);
    assign scan_slot = scan_w[3:0];
    assign pick      = found_reg ? best_reg : 4'd0;
    assign rd_e      = tab_reg[rd_idx];
    assign in_use    = rd_e.present || (cur_reg.slot == running_reg);
    assign wake_sum  = {1'b0, cur_reg.now} + {1'b0, div_q};
    assign scan_due  = (rd_e.ts == TS_SLEEPING) && (cur_reg.now >= rd_e.wake);
    assign scan_ts   = scan_due ? TS_READY : rd_e.ts;
    assign div_go    = (st_reg == B_DIV_GO);
    assign q_pop     = (st_reg == B_IDLE) && q_valid;

    assign done         = done_reg;
    assign status       = status_reg;
    assign chosen_slot  = chosen_reg;
    assign switched     = switched_reg;
    assign running_slot = running_reg;

    pts_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (prod_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // single table port: every step reads one entry and may write it back
    always_comb
    begin
        case (st_reg)
            B_EXEC:       rd_idx = (cur_reg.op == OP_SLEEP) ? run_w[IDX_W-1:0]
                                                            : slot_w[IDX_W-1:0];
            B_SLEEP_WR:   rd_idx = run_w[IDX_W-1:0];
            B_SCAN:       rd_idx = scan_reg[IDX_W-1:0];
            B_COMMIT_OLD: rd_idx = run_w[IDX_W-1:0];
            B_COMMIT_NEW: rd_idx = best_w[IDX_W-1:0];
            default:      rd_idx = slot_w[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = (q_item.op == OP_SCHEDULE) ? B_SCAN : B_EXEC;
                end
            end
            B_EXEC:
            begin
                st_next = (cur_reg.op == OP_SLEEP && running_reg != 4'd0) ? B_MUL : B_IDLE;
            end
            B_MUL:        st_next = B_DIV_GO;
            B_DIV_GO:     st_next = B_DIV;
            B_DIV:        st_next = div_done ? B_SLEEP_WR : B_DIV;
            B_SLEEP_WR:   st_next = B_IDLE;
            B_SCAN:       st_next = (scan_reg == SCAN_LAST) ? B_COMMIT_OLD : B_SCAN;
            B_COMMIT_OLD: st_next = (pick == running_reg) ? B_IDLE : B_COMMIT_NEW;
            B_COMMIT_NEW: st_next = B_IDLE;
            default:      st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        counter_next    = counter_reg;
        running_next    = running_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_prio_next  = best_prio_reg;
        best_stamp_next = best_stamp_reg;
        prod_next       = prod_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        chosen_next     = chosen_reg;
        switched_next   = switched_reg;
        tab_we          = 1'b0;
        wr_e            = rd_e;
        case (st_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next   = q_item;
                    scan_next  = (IDX_W + 1)'(1);
                    found_next = 1'b0;
                end
            end
            B_EXEC:
            begin
                status_next   = STAT_OK;
                chosen_next   = 4'd0;
                switched_next = 1'b0;
                done_next     = 1'b1;
                case (cur_reg.op)
                    OP_ENQUEUE:
                    begin
                        if (!cur_reg.slot_ok)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (in_use)
                        begin
                            status_next = STAT_PRESENT;
                        end
                        else
                        begin
                            tab_we       = 1'b1;
                            counter_next = counter_reg + 32'd1;
                            wr_e.present = 1'b1;
                            wr_e.ts      = TS_READY;
                            wr_e.prio    = cur_reg.prio;
                            wr_e.wake    = 64'd0;
                            wr_e.stamp   = counter_next;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!cur_reg.slot_ok || !rd_e.present)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            tab_we       = 1'b1;
                            wr_e.present = 1'b0;
                        end
                    end
                    OP_SET_PRIO:
                    begin
                        if (!cur_reg.slot_ok || !in_use)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            tab_we    = 1'b1;
                            wr_e.prio = cur_reg.prio;
                        end
                    end
                    OP_SLEEP:
                    begin
                        if (running_reg == 4'd0)
                        begin
                            status_next = STAT_NO_CUR;
                        end
                        else
                        begin
                            done_next = 1'b0;
                        end
                    end
                    OP_WAKE:
                    begin
                        if (!cur_reg.slot_ok || !in_use)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (rd_e.ts == TS_SLEEPING)
                        begin
                            tab_we    = 1'b1;
                            wr_e.ts   = (cur_reg.slot == running_reg) ? TS_RUNNING : TS_READY;
                            wr_e.wake = 64'd0;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            B_MUL:
            begin
                prod_next = 64'(cur_reg.sleep_ms) * 64'(tps_reg);
            end
            B_SLEEP_WR:
            begin
                // saturate the wake time on overflow
                tab_we    = 1'b1;
                wr_e.wake = wake_sum[64] ? {64{1'b1}} : wake_sum[63:0];
                wr_e.ts   = TS_SLEEPING;
                done_next = 1'b1;
            end
            B_SCAN:
            begin
                scan_next = scan_reg + (IDX_W + 1)'(1);
                if (rd_e.present)
                begin
                    if (scan_due)
                    begin
                        tab_we    = 1'b1;
                        wr_e.ts   = TS_READY;
                        wr_e.wake = 64'd0;
                    end
                    // ties go to the most recent stamp (enqueue or return to the table)
                    if (scan_ts == TS_READY &&
                        (!found_reg || rd_e.prio < best_prio_reg ||
                         (rd_e.prio == best_prio_reg && rd_e.stamp > best_stamp_reg)))
                    begin
                        found_next      = 1'b1;
                        best_next       = scan_slot;
                        best_prio_next  = rd_e.prio;
                        best_stamp_next = rd_e.stamp;
                    end
                end
            end
            B_COMMIT_OLD:
            begin
                status_next   = STAT_OK;
                chosen_next   = pick;
                switched_next = 1'b0;
                if (pick == running_reg)
                begin
                    done_next = 1'b1;
                end
                else if (running_reg != 4'd0)
                begin
                    // thread switched away from goes back into the table
                    tab_we       = 1'b1;
                    counter_next = counter_reg + 32'd1;
                    wr_e.present = 1'b1;
                    wr_e.ts      = (rd_e.ts == TS_SLEEPING) ? TS_SLEEPING : TS_READY;
                    wr_e.stamp   = counter_next;
                end
            end
            B_COMMIT_NEW:
            begin
                if (pick != 4'd0)
                begin
                    tab_we       = 1'b1;
                    wr_e.present = 1'b0;
                    wr_e.ts      = TS_RUNNING;
                end
                running_next  = pick;
                switched_next = 1'b1;
                done_next     = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= B_IDLE;
            tps_reg     <= TICKS_PER_S_RESET;
            counter_reg <= 32'd0;
            running_reg <= 4'd0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            scan_reg    <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                tab_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg      <= st_next;
            counter_reg <= counter_next;
            running_reg <= running_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            scan_reg    <= scan_next;
            if (cfg_valid)
            begin
                tps_reg <= cfg_data;
            end
            if (tab_we)
            begin
                tab_reg[rd_idx] <= wr_e;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_prio_reg  <= best_prio_next;
        best_stamp_reg <= best_stamp_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        chosen_reg     <= chosen_next;
        switched_reg   <= switched_next;
    end

endmodule

// ===== hw/rtl/pts_checker.sv =====
`timescale 1ns / 1ps

module pts_checker import pts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       done,
    input logic [1:0] status,
    input logic [3:0] chosen_slot,
    input logic       switched,
    input logic [3:0] running_slot
);

    // a switch always lands on the slot just chosen
    a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched) |-> (running_slot == chosen_slot))
        else $error("switch does not land on chosen slot");

    // the running slot only moves with a reported switch
    a_running_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(running_slot) |-> (done && switched))
        else $error("running slot changed without a switch");

    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched) |-> (status == STAT_OK))
        else $error("switch reported with error status");

    // every command passes through dispatch, so results are never back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back results");

endmodule

bind priority_thread_scheduler_unit pts_checker u_pts_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (done),
    .status       (status),
    .chosen_slot  (chosen_slot),
    .switched     (switched),
    .running_slot (running_slot)
);
